// ===== rtl/core/rate_monotonic_tick_scheduler_core_assert.svh =====
// Assertion macros for the scheduler core.
`ifndef RATE_MONOTONIC_TICK_SCHEDULER_CORE_ASSERT_SVH
`define RATE_MONOTONIC_TICK_SCHEDULER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define RMTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define RMTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/rmts_pkg.sv =====
package rmts_pkg;

    localparam int MAX_TASKS_DEF   = 8;
    localparam int PERIOD_BITS_DEF = 16;

    localparam int FUNC_W     = 2;
    localparam int IN_PER_W   = 16;
    localparam int NOW_W      = 32;
    localparam int READY_W    = 16;
    localparam int EXEC_W     = 32;
    localparam int SLOT_OUT_W = 3;
    localparam int STATUS_W   = 2;

    localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DONE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOCUR = 2'd2;

    typedef struct packed {
        logic load;
        logic rem_clr;
        logic rem_step;
        logic rel;
        logic scan;
        logic commit;
        logic retire;
    } t_cell_ctl;

endpackage

// ===== rtl/core/rmts_cell.sv =====
module rmts_cell #(
    parameter int INDEX       = 0,
    parameter int MAX_TASKS   = rmts_pkg::MAX_TASKS_DEF,
    parameter int PERIOD_BITS = rmts_pkg::PERIOD_BITS_DEF,
    parameter int SLOT_W      = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rmts_pkg::t_cell_ctl         i_ctl,
    input  logic [SLOT_W-1:0]           i_sel_slot,
    input  logic [PERIOD_BITS-1:0]      i_period,
    input  logic                        i_now_bit,
    input  logic                        i_best_valid,
    input  logic [PERIOD_BITS-1:0]      i_best_period,
    input  logic [SLOT_W-1:0]           i_best_slot,
    input  logic [rmts_pkg::EXEC_W-1:0] i_best_exec,
    output logic                        o_best_valid,
    output logic [PERIOD_BITS-1:0]      o_best_period,
    output logic [SLOT_W-1:0]           o_best_slot,
    output logic [rmts_pkg::EXEC_W-1:0] o_best_exec
);

    localparam logic [rmts_pkg::READY_W-1:0] READY_MAX = {rmts_pkg::READY_W{1'b1}};
    localparam logic [rmts_pkg::EXEC_W-1:0]  EXEC_MAX  = {rmts_pkg::EXEC_W{1'b1}};
    localparam logic [SLOT_W-1:0]            MY_SLOT   = SLOT_W'(INDEX);

    logic                          r_loaded, n_loaded;
    logic [PERIOD_BITS-1:0]        r_period, n_period;
    logic [rmts_pkg::READY_W-1:0]  r_ready, n_ready;
    logic [rmts_pkg::EXEC_W-1:0]   r_exec, n_exec;
    logic [PERIOD_BITS-1:0]        r_rem, n_rem;
    logic                          r_bv, n_bv;
    logic [PERIOD_BITS-1:0]        r_bp, n_bp;
    logic [SLOT_W-1:0]             r_bs, n_bs;
    logic [rmts_pkg::EXEC_W-1:0]   r_be, n_be;

    logic                          matched;
    logic [PERIOD_BITS:0]          rem_ext;
    logic [PERIOD_BITS:0]          per_ext;
    logic [PERIOD_BITS:0]          rem_diff;
    logic [rmts_pkg::EXEC_W-1:0]   exec_inc;
    logic                          own_ok;
    logic                          take;

    always_comb begin
        matched  = (i_sel_slot == MY_SLOT);
        rem_ext  = {r_rem, i_now_bit};
        per_ext  = {1'b0, r_period};
        rem_diff = rem_ext - per_ext;
        exec_inc = (r_exec == EXEC_MAX) ? r_exec : r_exec + 1'b1;
        own_ok   = r_loaded && (r_ready != '0);
        take     = own_ok && (!i_best_valid || (r_period < i_best_period));

        n_loaded = r_loaded;
        n_period = r_period;
        n_ready  = r_ready;
        n_exec   = r_exec;
        n_rem    = r_rem;
        n_bv     = r_bv;
        n_bp     = r_bp;
        n_bs     = r_bs;
        n_be     = r_be;

        if (i_ctl.load && matched) begin
            n_loaded = 1'b1;
            n_period = i_period;
            n_ready  = '0;
            n_exec   = '0;
        end
        if (i_ctl.rem_clr) begin
            n_rem = '0;
        end
        if (i_ctl.rem_step) begin
            n_rem = (rem_ext >= per_ext) ? rem_diff[PERIOD_BITS-1:0]
                                         : rem_ext[PERIOD_BITS-1:0];
        end
        if (i_ctl.rel && r_loaded && (r_period != '0) && (r_rem == '0)
                && (r_ready != READY_MAX)) begin
            n_ready = r_ready + 1'b1;
        end
        if (i_ctl.scan) begin
            n_bv = take ? 1'b1     : i_best_valid;
            n_bp = take ? r_period : i_best_period;
            n_bs = take ? MY_SLOT  : i_best_slot;
            n_be = take ? exec_inc : i_best_exec;
        end
        if (i_ctl.commit && matched) begin
            n_exec = exec_inc;
        end
        if (i_ctl.retire && matched && (r_ready != '0)) begin
            n_ready = r_ready - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= 1'b0;
            r_ready  <= '0;
            r_exec   <= '0;
        end else begin
            r_loaded <= n_loaded;
            r_ready  <= n_ready;
            r_exec   <= n_exec;
        end
    end

    always_ff @(posedge i_clk) begin
        r_period <= n_period;
        r_rem    <= n_rem;
        r_bv     <= n_bv;
        r_bp     <= n_bp;
        r_bs     <= n_bs;
        r_be     <= n_be;
    end

    assign o_best_valid  = r_bv;
    assign o_best_period = r_bp;
    assign o_best_slot   = r_bs;
    assign o_best_exec   = r_be;

endmodule

// ===== rtl/core/rate_monotonic_tick_scheduler_core.sv =====
// Channel  Direction  Handshake          Fields
// in       sink       i_valid / o_stall  i_func, i_task_period, i_now_time
// out      source     o_valid / i_stall  o_run_valid, o_run_slot, o_run_count, o_status
//
// Load, done and unknown beats go from accept straight to the emit step.
// Tick beats run the bit-serial remainder in every slot cell, a release step and the
// best-candidate walk down the cell row, then the commit and emit steps.
// One beat at a time; a new beat is taken while a result waits on the output.
// Reset is synchronous, active low; counts and loaded flags clear at once.
// A stalled output holds the scheduler in its final step until the register drains.
`include "rate_monotonic_tick_scheduler_core_assert.svh"

module rate_monotonic_tick_scheduler_core #(
    parameter int MAX_TASKS   = rmts_pkg::MAX_TASKS_DEF,
    parameter int PERIOD_BITS = rmts_pkg::PERIOD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [rmts_pkg::FUNC_W-1:0]     i_func,
    input  logic [rmts_pkg::IN_PER_W-1:0]   i_task_period,
    input  logic [rmts_pkg::NOW_W-1:0]      i_now_time,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_run_valid,
    output logic [rmts_pkg::SLOT_OUT_W-1:0] o_run_slot,
    output logic [rmts_pkg::EXEC_W-1:0]     o_run_count,
    output logic [rmts_pkg::STATUS_W-1:0]   o_status
);

    localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int TOT_W  = $clog2(MAX_TASKS + 1);
    localparam int CNT_W  = $clog2((rmts_pkg::NOW_W > MAX_TASKS) ? rmts_pkg::NOW_W
                                                                  : MAX_TASKS);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DIV    = 6'b000010,
        S_REL    = 6'b000100,
        S_SCAN   = 6'b001000,
        S_COMMIT = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    t_state                           r_state, n_state;
    logic [CNT_W-1:0]                 r_cnt, n_cnt;
    logic [rmts_pkg::NOW_W-1:0]       r_now, n_now;
    logic [TOT_W-1:0]                 r_total, n_total;
    logic [SLOT_W-1:0]                r_cur_slot, n_cur_slot;
    logic                             r_cur_valid, n_cur_valid;
    logic                             r_res_valid, n_res_valid;
    logic [rmts_pkg::SLOT_OUT_W-1:0]  r_res_slot, n_res_slot;
    logic [rmts_pkg::EXEC_W-1:0]      r_res_count, n_res_count;
    logic [rmts_pkg::STATUS_W-1:0]    r_res_status, n_res_status;
    logic                             r_out_valid, n_out_valid;
    logic                             r_o_run_valid;
    logic [rmts_pkg::SLOT_OUT_W-1:0]  r_o_run_slot;
    logic [rmts_pkg::EXEC_W-1:0]      r_o_run_count;
    logic [rmts_pkg::STATUS_W-1:0]    r_o_status;

    rmts_pkg::t_cell_ctl              ctl;
    logic [SLOT_W-1:0]                sel_slot;
    logic [PERIOD_BITS-1:0]           in_period;
    logic                             in_acc;
    logic                             out_load;

    logic                             bv [MAX_TASKS+1];
    logic [PERIOD_BITS-1:0]           bp [MAX_TASKS+1];
    logic [SLOT_W-1:0]                bs [MAX_TASKS+1];
    logic [rmts_pkg::EXEC_W-1:0]      be [MAX_TASKS+1];

    assign bv[0] = 1'b0;
    assign bp[0] = '0;
    assign bs[0] = '0;
    assign be[0] = '0;

    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
        rmts_cell #(
            .INDEX       (g),
            .MAX_TASKS   (MAX_TASKS),
            .PERIOD_BITS (PERIOD_BITS),
            .SLOT_W      (SLOT_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_sel_slot    (sel_slot),
            .i_period      (in_period),
            .i_now_bit     (r_now[rmts_pkg::NOW_W-1]),
            .i_best_valid  (bv[g]),
            .i_best_period (bp[g]),
            .i_best_slot   (bs[g]),
            .i_best_exec   (be[g]),
            .o_best_valid  (bv[g+1]),
            .o_best_period (bp[g+1]),
            .o_best_slot   (bs[g+1]),
            .o_best_exec   (be[g+1])
        );
    end

    assign in_period = PERIOD_BITS'(i_task_period);
    assign o_stall   = (r_state != S_IDLE);
    assign in_acc    = i_valid && (r_state == S_IDLE);
    assign out_load  = (r_state == S_EMIT) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_now        = r_now;
        n_total      = r_total;
        n_cur_slot   = r_cur_slot;
        n_cur_valid  = r_cur_valid;
        n_res_valid  = r_res_valid;
        n_res_slot   = r_res_slot;
        n_res_count  = r_res_count;
        n_res_status = r_res_status;
        ctl          = '0;
        sel_slot     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res_valid  = 1'b0;
                    n_res_slot   = '0;
                    n_res_count  = '0;
                    n_res_status = rmts_pkg::STATUS_OK;
                    n_state      = S_EMIT;
                    unique case (i_func)
                        rmts_pkg::FUNC_LOAD: begin
                            if (r_total == TOT_W'(MAX_TASKS)) begin
                                n_res_status = rmts_pkg::STATUS_FULL;
                            end else begin
                                ctl.load   = 1'b1;
                                sel_slot   = SLOT_W'(r_total);
                                n_total    = r_total + 1'b1;
                                n_res_slot = rmts_pkg::SLOT_OUT_W'(r_total);
                            end
                        end
                        rmts_pkg::FUNC_TICK: begin
                            ctl.rem_clr = 1'b1;
                            n_now       = i_now_time;
                            n_cnt       = CNT_W'(rmts_pkg::NOW_W - 1);
                            n_state     = S_DIV;
                        end
                        rmts_pkg::FUNC_DONE: begin
                            if (r_cur_valid) begin
                                ctl.retire  = 1'b1;
                                sel_slot    = r_cur_slot;
                                n_cur_valid = 1'b0;
                                n_res_slot  = rmts_pkg::SLOT_OUT_W'(r_cur_slot);
                            end else begin
                                n_res_status = rmts_pkg::STATUS_NOCUR;
                            end
                        end
                        default: begin
                            n_res_status = rmts_pkg::STATUS_OK;
                        end
                    endcase
                end
            end
            S_DIV: begin
                ctl.rem_step = 1'b1;
                n_now        = r_now << 1;
                if (r_cnt == '0) begin
                    n_state = S_REL;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_REL: begin
                ctl.rel = 1'b1;
                n_cnt   = CNT_W'(MAX_TASKS - 1);
                n_state = S_SCAN;
            end
            S_SCAN: begin
                ctl.scan = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_COMMIT;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_COMMIT: begin
                if (bv[MAX_TASKS]) begin
                    ctl.commit  = 1'b1;
                    sel_slot    = bs[MAX_TASKS];
                    n_cur_slot  = bs[MAX_TASKS];
                    n_cur_valid = 1'b1;
                    n_res_valid = 1'b1;
                    n_res_slot  = rmts_pkg::SLOT_OUT_W'(bs[MAX_TASKS]);
                    n_res_count = be[MAX_TASKS];
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = out_load ? 1'b1 : (r_out_valid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_cur_slot  <= '0;
            r_cur_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_cur_slot  <= n_cur_slot;
            r_cur_valid <= n_cur_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt        <= n_cnt;
        r_now        <= n_now;
        r_res_valid  <= n_res_valid;
        r_res_slot   <= n_res_slot;
        r_res_count  <= n_res_count;
        r_res_status <= n_res_status;
        if (out_load) begin
            r_o_run_valid <= r_res_valid;
            r_o_run_slot  <= r_res_slot;
            r_o_run_count <= r_res_count;
            r_o_status    <= r_res_status;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_run_valid = r_o_run_valid;
    assign o_run_slot  = r_o_run_slot;
    assign o_run_count = r_o_run_count;
    assign o_status    = r_o_status;

    `RMTS_ASSERT_NOW(a_total_bound, 1'b1, r_total <= TOT_W'(MAX_TASKS), "slot count past table size")
    `RMTS_ASSERT_NEXT(a_tick_starts_div, in_acc && (i_func == rmts_pkg::FUNC_TICK), r_state == S_DIV, "tick did not start remainder pass")
    `RMTS_ASSERT_NEXT(a_commit_sets_cur, (r_state == S_COMMIT) && bv[MAX_TASKS], r_cur_valid && (r_cur_slot == $past(bs[MAX_TASKS])), "chosen task not made current")
    `RMTS_ASSERT_NOW(a_rise_from_emit, $rose(r_out_valid), $past(r_state == S_EMIT), "output filled outside emit step")

endmodule

// ===== tb/sv/rate_monotonic_tick_scheduler_checker.sv =====
`timescale 1ns / 100ps

module rate_monotonic_tick_scheduler_checker #(
    parameter int MAX_TASKS   = rmts_pkg::MAX_TASKS_DEF,
    parameter int PERIOD_BITS = rmts_pkg::PERIOD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [rmts_pkg::FUNC_W-1:0]     i_func,
    input  logic [rmts_pkg::IN_PER_W-1:0]   i_task_period,
    input  logic [rmts_pkg::NOW_W-1:0]      i_now_time,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic                            i_run_valid,
    input  logic [rmts_pkg::SLOT_OUT_W-1:0] i_run_slot,
    input  logic [rmts_pkg::EXEC_W-1:0]     i_run_count,
    input  logic [rmts_pkg::STATUS_W-1:0]   i_status,
    output int                              o_fail_count,
    output int                              o_pending
);

    typedef struct packed {
        logic                            run_valid;
        logic [rmts_pkg::SLOT_OUT_W-1:0] run_slot;
        logic [rmts_pkg::EXEC_W-1:0]     run_count;
        logic [rmts_pkg::STATUS_W-1:0]   status;
    } t_dispatch;

    localparam logic [rmts_pkg::READY_W-1:0] READY_SAT = '1;
    localparam logic [rmts_pkg::EXEC_W-1:0]  RUNS_SAT  = '1;

    logic [PERIOD_BITS-1:0]       slot_period [MAX_TASKS];
    logic [rmts_pkg::READY_W-1:0] slot_ready  [MAX_TASKS];
    logic [rmts_pkg::EXEC_W-1:0]  slot_runs   [MAX_TASKS];
    int                           loaded_tasks;
    int                           current_task;
    bit                           has_current;
    t_dispatch                    dispatch_queue [$];
    int                           fails = 0;

    assign o_fail_count = fails;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: scheduler mismatch: %s", $time, msg);
        fails++;
    endtask

    task automatic dispatch_beat(
        input  logic [rmts_pkg::FUNC_W-1:0]   func,
        input  logic [rmts_pkg::IN_PER_W-1:0] period,
        input  logic [rmts_pkg::NOW_W-1:0]    now,
        output t_dispatch                     res
    );
        bit found;
        int best;
        res   = '0;
        found = 1'b0;
        best  = 0;
        unique case (func)
            rmts_pkg::FUNC_LOAD: begin
                if (loaded_tasks >= MAX_TASKS) begin
                    res.status = rmts_pkg::STATUS_FULL;
                end else begin
                    slot_period[loaded_tasks] = PERIOD_BITS'(period);
                    slot_ready[loaded_tasks]  = '0;
                    slot_runs[loaded_tasks]   = '0;
                    res.run_slot = rmts_pkg::SLOT_OUT_W'(loaded_tasks);
                    loaded_tasks++;
                end
            end
            rmts_pkg::FUNC_TICK: begin
                // release every task whose period divides the time
                for (int i = 0; i < loaded_tasks; i++) begin
                    if (slot_period[i] != 0 && now % slot_period[i] == 0 &&
                        slot_ready[i] != READY_SAT)
                        slot_ready[i]++;
                end
                // shortest period wins, lower slot on a tie
                for (int i = 0; i < loaded_tasks; i++) begin
                    if (slot_ready[i] != 0 &&
                        (!found || slot_period[i] < slot_period[best])) begin
                        found = 1'b1;
                        best  = i;
                    end
                end
                if (found) begin
                    current_task = best;
                    has_current  = 1'b1;
                    if (slot_runs[best] != RUNS_SAT)
                        slot_runs[best]++;
                    res.run_valid = 1'b1;
                    res.run_slot  = rmts_pkg::SLOT_OUT_W'(best);
                    res.run_count = slot_runs[best];
                end
            end
            rmts_pkg::FUNC_DONE: begin
                if (has_current) begin
                    if (slot_ready[current_task] != 0)
                        slot_ready[current_task]--;
                    has_current  = 1'b0;
                    res.run_slot = rmts_pkg::SLOT_OUT_W'(current_task);
                end else begin
                    res.status = rmts_pkg::STATUS_NOCUR;
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_dispatch want;
        t_dispatch fresh;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TASKS; i++) begin
                slot_period[i] = '0;
                slot_ready[i]  = '0;
                slot_runs[i]   = '0;
            end
            loaded_tasks = 0;
            current_task = 0;
            has_current  = 1'b0;
            dispatch_queue.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (dispatch_queue.size() == 0) begin
                    report_mismatch($sformatf("result beat (slot %0d, status %0d) with nothing due",
                                              i_run_slot, i_status));
                end else begin
                    want = dispatch_queue.pop_front();
                    if (i_run_valid != want.run_valid)
                        report_mismatch($sformatf("run_valid got %0d want %0d",
                                                  i_run_valid, want.run_valid));
                    if (i_run_slot != want.run_slot)
                        report_mismatch($sformatf("run_slot got %0d want %0d",
                                                  i_run_slot, want.run_slot));
                    if (i_run_count != want.run_count)
                        report_mismatch($sformatf("run_count got %0d want %0d",
                                                  i_run_count, want.run_count));
                    if (i_status != want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  i_status, want.status));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                dispatch_beat(i_func, i_task_period, i_now_time, fresh);
                dispatch_queue.push_back(fresh);
            end
        end
        o_pending <= dispatch_queue.size();
    end

endmodule

// ===== tb/sv/tb_rate_monotonic_tick_scheduler_core.sv =====
`timescale 1ns / 100ps

module tb_rate_monotonic_tick_scheduler_core;

    localparam logic [rmts_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;

    localparam int RANDOM_BEATS = 1500;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_START   = 3000;
    localparam int HOLD_LEN     = 500;
    localparam int DRAIN_CYCLES = 64;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic [rmts_pkg::FUNC_W-1:0]     in_func;
    logic [rmts_pkg::IN_PER_W-1:0]   in_period;
    logic [rmts_pkg::NOW_W-1:0]      in_now;
    logic                            out_valid;
    logic                            out_stall;
    logic                            out_run_valid;
    logic [rmts_pkg::SLOT_OUT_W-1:0] out_run_slot;
    logic [rmts_pkg::EXEC_W-1:0]     out_run_count;
    logic [rmts_pkg::STATUS_W-1:0]   out_status;
    int                              fail_count;
    int                              pending;
    logic [rmts_pkg::NOW_W-1:0]      tick_time = '0;

    always #6 clk = ~clk;

    rate_monotonic_tick_scheduler_core u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (in_valid),
        .o_stall       (in_stall),
        .i_func        (in_func),
        .i_task_period (in_period),
        .i_now_time    (in_now),
        .o_valid       (out_valid),
        .i_stall       (out_stall),
        .o_run_valid   (out_run_valid),
        .o_run_slot    (out_run_slot),
        .o_run_count   (out_run_count),
        .o_status      (out_status)
    );

    rate_monotonic_tick_scheduler_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_func        (in_func),
        .i_task_period (in_period),
        .i_now_time    (in_now),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_run_valid   (out_run_valid),
        .i_run_slot    (out_run_slot),
        .i_run_count   (out_run_count),
        .i_status      (out_status),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    task automatic send_beat(
        input logic [rmts_pkg::FUNC_W-1:0]   f,
        input logic [rmts_pkg::IN_PER_W-1:0] p,
        input logic [rmts_pkg::NOW_W-1:0]    n
    );
        in_valid  <= 1'b1;
        in_func   <= f;
        in_period <= p;
        in_now    <= n;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic pick_beat(
        output logic [rmts_pkg::FUNC_W-1:0]   f,
        output logic [rmts_pkg::IN_PER_W-1:0] p,
        output logic [rmts_pkg::NOW_W-1:0]    n
    );
        int unsigned pick;
        pick = $urandom_range(0, 99);
        p    = rmts_pkg::IN_PER_W'($urandom);
        n    = $urandom;
        if (pick < 45) begin
            f = rmts_pkg::FUNC_TICK;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    tick_time += $urandom_range(1, 4);
                    n = tick_time;
                end
                4, 5, 6: n = $urandom_range(0, 71582788) * 60;
                7, 8:    n = $urandom;
                default: n = pick[0] ? 32'hFFFF_FFFF : $urandom_range(0, 65537) * 65535;
            endcase
        end else if (pick < 80) begin
            f = rmts_pkg::FUNC_DONE;
        end else if (pick < 92) begin
            f = rmts_pkg::FUNC_LOAD;
            case ($urandom_range(0, 4))
                0:       p = 16'd1;
                1:       p = 16'hFFFF;
                2:       p = 16'd0;
                default: p = rmts_pkg::IN_PER_W'($urandom);
            endcase
        end else begin
            f = FUNC_NONE;
        end
    endtask

    initial begin
        logic [rmts_pkg::FUNC_W-1:0]   f;
        logic [rmts_pkg::IN_PER_W-1:0] p;
        logic [rmts_pkg::NOW_W-1:0]    n;
        int unsigned                   burst;
        int unsigned                   gap;
        int                            beats;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_func   <= rmts_pkg::FUNC_LOAD;
        in_period <= '0;
        in_now    <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(rmts_pkg::FUNC_DONE, 16'd0, 32'd0);
        send_beat(rmts_pkg::FUNC_TICK, 16'hFFFF, 32'd0);
        send_beat(FUNC_NONE, 16'hFFFF, 32'hFFFF_FFFF);
        send_beat(rmts_pkg::FUNC_LOAD, 16'd0, 32'd0);
        send_beat(rmts_pkg::FUNC_LOAD, 16'hFFFF, 32'd0);
        send_beat(rmts_pkg::FUNC_LOAD, 16'd6, 32'd0);
        send_beat(rmts_pkg::FUNC_TICK, 16'd0, 32'd7);
        send_beat(rmts_pkg::FUNC_TICK, 16'd0, 32'd12);
        send_beat(rmts_pkg::FUNC_DONE, 16'd0, 32'd0);
        send_beat(rmts_pkg::FUNC_DONE, 16'd0, 32'd0);
        send_beat(rmts_pkg::FUNC_LOAD, 16'd4, 32'd0);
        send_beat(rmts_pkg::FUNC_LOAD, 16'd6, 32'd0);
        send_beat(rmts_pkg::FUNC_LOAD, 16'd10, 32'd0);
        send_beat(rmts_pkg::FUNC_LOAD, 16'd15, 32'd0);
        send_beat(rmts_pkg::FUNC_LOAD, 16'd12, 32'd0);
        send_beat(rmts_pkg::FUNC_LOAD, 16'd1, 32'd0);
        send_beat(rmts_pkg::FUNC_TICK, 16'd0, 32'd0);
        send_beat(rmts_pkg::FUNC_DONE, 16'd0, 32'd0);
        send_beat(rmts_pkg::FUNC_TICK, 16'd0, 32'hFFFF_FFFF);
        send_beat(rmts_pkg::FUNC_DONE, 16'd0, 32'd0);
        send_beat(rmts_pkg::FUNC_TICK, 16'd0, 32'd7);
        send_beat(rmts_pkg::FUNC_LOAD, 16'hFFFF, 32'd0);
        send_beat(FUNC_NONE, 16'd0, 32'd0);

        beats = 0;
        while (beats < RANDOM_BEATS) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
                pick_beat(f, p, n);
                send_beat(f, p, n);
                beats++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // stall on windows of varying density; hold off once to back up the block
    initial begin
        int rx_cycle;
        int stall_pct;
        out_stall <= 1'b0;
        rx_cycle  = 0;
        stall_pct = 0;
        forever begin
            @(posedge clk);
            rx_cycle++;
            if (rx_cycle % 128 == 0) begin
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 15;
                    2:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
                out_stall <= 1'b1;
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/rmts_pkg.sv
rtl/core/rmts_cell.sv
rtl/core/rate_monotonic_tick_scheduler_core.sv
tb/sv/rate_monotonic_tick_scheduler_checker.sv
tb/sv/tb_rate_monotonic_tick_scheduler_core.sv
